FILE: rtl/dgmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth grid mesh indexer package
// Shared widths, codes, word types and the triangle corner table.
// ----------------------------------------------------------------------------
package dgmi_pkg;

   // Vertex numbering.
   localparam int NUM_W   = 20;
   localparam int COUNT_W = 21;
   localparam logic [COUNT_W-1:0] NUM_LIMIT = 21'h100000;

   // Store entry: epoch tag above the vertex number.
   localparam int EPOCH_W = 12;
   localparam int ENTRY_W = EPOCH_W + NUM_W;
   localparam logic [EPOCH_W-1:0] EPOCH_STALE = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 12'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;

   // Result list of one quad.
   localparam int REC_MAX   = 10;
   localparam int REC_IDX_W = 4;

   // Width used for column and edge arithmetic (covers twice the widest grid).
   localparam int CALC_W = 14;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_QUAD  = 1'b1
   } command_type;

   typedef enum logic {
      KIND_VERTEX = 1'b0,
      KIND_INDEX  = 1'b1
   } kind_type;

   typedef struct packed {
      logic        command;
      logic [9:0]  grid_x;
      logic [9:0]  grid_y;
      logic [15:0] depth_top_left;
      logic [15:0] depth_top_right;
      logic [15:0] depth_bottom_left;
      logic [15:0] depth_bottom_right;
   } req_word_type;

   typedef struct packed {
      kind_type         kind;
      logic [1:0]       corner;
      logic [NUM_W-1:0] vertex_number;
      logic             last;
   } rsp_word_type;

   typedef struct packed {
      logic               sweeping;
      logic [COUNT_W-1:0] next_vertex;
   } status_type;

   // Corners of triangles 0-1-2 and 2-1-3, in emission order.
   function automatic logic [1:0] tri_corner(input logic [2:0] k);
      logic [1:0] c;
      unique case (k)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd1;
         3'd2:    c = 2'd2;
         3'd3:    c = 2'd2;
         3'd4:    c = 2'd1;
         default: c = 2'd3;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/dgmi_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad request channel
// Valid/ready channel that carries one grid quad or a frame start per word.
// ----------------------------------------------------------------------------
interface dgmi_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [9:0]  grid_x;
   logic [9:0]  grid_y;
   logic [15:0] depth_top_left;
   logic [15:0] depth_top_right;
   logic [15:0] depth_bottom_left;
   logic [15:0] depth_bottom_right;

   modport source (
      output valid, command, grid_x, grid_y,
             depth_top_left, depth_top_right, depth_bottom_left, depth_bottom_right,
      input  ready
   );

   modport sink (
      input  valid, command, grid_x, grid_y,
             depth_top_left, depth_top_right, depth_bottom_left, depth_bottom_right,
      output ready
   );
endinterface

FILE: rtl/dgmi_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh record channel
// Valid/ready channel that carries one vertex or index record per word.
// ----------------------------------------------------------------------------
interface dgmi_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  corner;
   logic [19:0] vertex_number;
   logic        last;

   modport source (
      output valid, kind, corner, vertex_number, last,
      input  ready
   );

   modport sink (
      input  valid, kind, corner, vertex_number, last,
      output ready
   );
endinterface

FILE: rtl/depth_grid_mesh_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth grid mesh indexer
// Turns depth-grid quads into new-vertex and triangle-index records, with
// vertex numbers kept in a two-row store.
// ----------------------------------------------------------------------------
// Flow: a quad taken from the input buffer passes the read-top, read-bottom
// and evaluate states, then emits its n records (3 to 10) through the output
// register, paced by the single record channel and the two-port corner reads;
// a frame start or a quad dropped at decode ends in the idle state, one out
// of numbers at evaluate. Reset: synchronous; a clearing pass over both row
// halves follows, and a pass over one half runs when that half's epoch wraps.
module depth_grid_mesh_indexer
   import dgmi_pkg::*;
#(
   parameter int GRID_WIDTH_MAX  = 1024,
   parameter int GRID_HEIGHT_MAX = 1024
) (
   input  logic        clock,
   input  logic        reset,
   dgmi_req_if.sink    req_chan,
   dgmi_rsp_if.source  rsp_chan
);

   localparam int DEPTH  = 2 * GRID_WIDTH_MAX;
   localparam int ADDR_W = $clog2(DEPTH);

   // Input word buffer.
   logic         buf_valid_ff, buf_valid_in;
   req_word_type buf_ff, buf_in;
   logic         take;

   // Output word register.
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic               rec_valid;
   rsp_word_type       rec_word;
   logic               rec_ready;
   logic               st_wr_en;
   logic [ADDR_W-1:0]  st_wr_addr;
   logic [ENTRY_W-1:0] st_wr_data;
   logic [ADDR_W-1:0]  st_rd_addr_a;
   logic [ADDR_W-1:0]  st_rd_addr_b;
   logic [ENTRY_W-1:0] st_rd_data_a;
   logic [ENTRY_W-1:0] st_rd_data_b;
   status_type         status;

   // Input buffer: a word is taken in while the sequencer works on another.
   assign req_chan.ready = !buf_valid_ff || take;

   always_comb begin
      buf_in       = buf_ff;
      buf_valid_in = buf_valid_ff && !take;
      if (req_chan.valid && req_chan.ready) begin
         buf_valid_in              = 1'b1;
         buf_in.command            = req_chan.command;
         buf_in.grid_x             = req_chan.grid_x;
         buf_in.grid_y             = req_chan.grid_y;
         buf_in.depth_top_left     = req_chan.depth_top_left;
         buf_in.depth_top_right    = req_chan.depth_top_right;
         buf_in.depth_bottom_left  = req_chan.depth_bottom_left;
         buf_in.depth_bottom_right = req_chan.depth_bottom_right;
      end
   end

   // Output register: loads whenever it is empty or being drained.
   assign rec_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (rec_valid && rec_ready) begin
         out_valid_in = 1'b1;
         out_in       = rec_word;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_ff.kind;
   assign rsp_chan.corner        = out_ff.corner;
   assign rsp_chan.vertex_number = out_ff.vertex_number;
   assign rsp_chan.last          = out_ff.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         out_valid_ff <= out_valid_in;
      end
      buf_ff <= buf_in;
      out_ff <= out_in;
   end

   dgmi_engine #(
      .GRID_WIDTH_MAX  (GRID_WIDTH_MAX),
      .GRID_HEIGHT_MAX (GRID_HEIGHT_MAX),
      .ADDR_W          (ADDR_W)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (buf_valid_ff),
      .in_word      (buf_ff),
      .in_take      (take),
      .rec_valid    (rec_valid),
      .rec_word     (rec_word),
      .rec_ready    (rec_ready),
      .st_wr_en     (st_wr_en),
      .st_wr_addr   (st_wr_addr),
      .st_wr_data   (st_wr_data),
      .st_rd_addr_a (st_rd_addr_a),
      .st_rd_addr_b (st_rd_addr_b),
      .st_rd_data_a (st_rd_data_a),
      .st_rd_data_b (st_rd_data_b),
      .status       (status)
   );

   dgmi_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (st_wr_en),
      .wr_addr   (st_wr_addr),
      .wr_data   (st_wr_data),
      .rd_addr_a (st_rd_addr_a),
      .rd_addr_b (st_rd_addr_b),
      .rd_data_a (st_rd_data_a),
      .rd_data_b (st_rd_data_b)
   );

   // No record is produced while a row half is being swept.
   a_no_record_in_sweep: assert property (@(posedge clock) disable iff (reset)
      status.sweeping |-> !rec_valid)
      else $error("record produced during store sweep");

   // The vertex counter never passes the numbering limit.
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      status.next_vertex <= NUM_LIMIT)
      else $error("vertex counter beyond limit");

   // A new vertex always carries a number already counted out.
   a_vertex_counted: assert property (@(posedge clock) disable iff (reset)
      (rec_valid && (rec_word.kind == KIND_VERTEX)) |->
      ({1'b0, rec_word.vertex_number} < status.next_vertex))
      else $error("new vertex number not below counter");

endmodule

FILE: rtl/dgmi_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-row vertex store
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module dgmi_store
   import dgmi_pkg::*;
#(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr_a,
   input  logic [ADDR_W-1:0]  rd_addr_b,
   output logic [ENTRY_W-1:0] rd_data_a,
   output logic [ENTRY_W-1:0] rd_data_b
);

   logic [ENTRY_W-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

FILE: rtl/dgmi_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quad sequencer
// Tracks rows and epochs, reads the four corners from the store, assigns new
// vertex numbers, and steps through the quad's records writing new vertices
// back to the store.
// ----------------------------------------------------------------------------
module dgmi_engine
   import dgmi_pkg::*;
#(
   parameter int GRID_WIDTH_MAX  = 1024,
   parameter int GRID_HEIGHT_MAX = 1024,
   parameter int ADDR_W          = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  req_word_type       in_word,
   output logic               in_take,
   output logic               rec_valid,
   output rsp_word_type       rec_word,
   input  logic               rec_ready,
   output logic               st_wr_en,
   output logic [ADDR_W-1:0]  st_wr_addr,
   output logic [ENTRY_W-1:0] st_wr_data,
   output logic [ADDR_W-1:0]  st_rd_addr_a,
   output logic [ADDR_W-1:0]  st_rd_addr_b,
   input  logic [ENTRY_W-1:0] st_rd_data_a,
   input  logic [ENTRY_W-1:0] st_rd_data_b,
   output status_type         status
);

   localparam int CTR_W = $clog2(GRID_WIDTH_MAX);
   localparam logic [CALC_W-1:0] WIDTH_C  = CALC_W'(GRID_WIDTH_MAX);
   localparam logic [CALC_W-1:0] HEIGHT_C = CALC_W'(GRID_HEIGHT_MAX);
   localparam logic [CTR_W-1:0]  CTR_LAST = CTR_W'(GRID_WIDTH_MAX - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_TOP,
      ST_READ_BOTTOM,
      ST_EVAL,
      ST_EMIT,
      ST_SWEEP
   } state_type;

   // Control state.
   state_type            state_ff, state_in;
   logic                 busy_ff, busy_in;
   logic [9:0]           row_ff, row_in;
   logic [COUNT_W-1:0]   nv_ff, nv_in;
   logic [EPOCH_W-1:0]   epoch_ff [2];
   logic [EPOCH_W-1:0]   epoch_in [2];
   logic [1:0]           pend_ff, pend_in;
   logic [CTR_W-1:0]     ctr_ff, ctr_in;
   logic [REC_IDX_W-1:0] rec_idx_ff, rec_idx_in;

   // Payload of the quad at work.
   logic [ADDR_W-1:0]    addr_ff [4];
   logic [ADDR_W-1:0]    addr_in [4];
   logic [3:0]           valid_ff, valid_in;
   logic                 y0_ff, y0_in;
   logic [ENTRY_W-1:0]   top_ent_ff [2];
   logic [ENTRY_W-1:0]   top_ent_in [2];
   logic [NUM_W-1:0]     num_ff [4];
   logic [NUM_W-1:0]     num_in [4];
   kind_type             rec_kind_ff [REC_MAX];
   kind_type             rec_kind_in [REC_MAX];
   logic [1:0]           rec_corner_ff [REC_MAX];
   logic [1:0]           rec_corner_in [REC_MAX];
   logic [REC_IDX_W-1:0] rec_cnt_ff, rec_cnt_in;

   // Store address of a corner: row parity picks the half, column the entry.
   function automatic logic [ADDR_W-1:0] corner_addr(input logic [9:0] x,
                                                     input logic y0,
                                                     input logic [1:0] c);
      logic [CALC_W-1:0] col;
      logic [CALC_W-1:0] full;
      col  = {{(CALC_W-10){1'b0}}, x} + CALC_W'(c[0]);
      full = (y0 ^ c[1]) ? col + WIDTH_C : col;
      return full[ADDR_W-1:0];
   endfunction

   // Current record and its write-back.
   logic [1:0] cur_corner;
   assign cur_corner              = rec_corner_ff[rec_idx_ff];
   assign rec_word.kind           = rec_kind_ff[rec_idx_ff];
   assign rec_word.corner         = cur_corner;
   assign rec_word.vertex_number  = num_ff[cur_corner];
   assign rec_word.last           = (rec_idx_ff == rec_cnt_ff - REC_IDX_W'(1));

   assign status.sweeping    = (state_ff == ST_SWEEP);
   assign status.next_vertex = nv_ff;

   // Next-state logic.
   always_comb begin
      logic [ENTRY_W-1:0]   ent [4];
      logic [3:0]           fresh;
      logic [NUM_W-1:0]     num_calc [4];
      logic [2:0]           off;
      logic                 exhausted;
      logic                 full_quad;
      logic [REC_IDX_W-1:0] n;
      logic [1:0]           ci;
      logic                 slot;
      logic [1:0]           bump;
      logic [3:0]           qv;
      logic [2:0]           qv_cnt;
      logic                 past_edge;
      logic                 sel;
      logic [CALC_W-1:0]    sweep_addr;

      state_in   = state_ff;
      busy_in    = busy_ff;
      row_in     = row_ff;
      nv_in      = nv_ff;
      epoch_in   = epoch_ff;
      pend_in    = pend_ff;
      ctr_in     = ctr_ff;
      rec_idx_in = rec_idx_ff;
      addr_in    = addr_ff;
      valid_in   = valid_ff;
      y0_in      = y0_ff;
      top_ent_in = top_ent_ff;
      num_in     = num_ff;
      rec_kind_in   = rec_kind_ff;
      rec_corner_in = rec_corner_ff;
      rec_cnt_in    = rec_cnt_ff;

      in_take      = 1'b0;
      rec_valid    = 1'b0;
      st_wr_en     = 1'b0;
      st_wr_addr   = addr_ff[cur_corner];
      st_wr_data   = {epoch_ff[y0_ff ^ cur_corner[1]], num_ff[cur_corner]};
      st_rd_addr_a = addr_ff[0];
      st_rd_addr_b = addr_ff[1];
      bump         = 2'b00;

      // Corner evaluation: an entry counts as assigned when its tag matches
      // the live epoch of its row half.
      ent[0] = top_ent_ff[0];
      ent[1] = top_ent_ff[1];
      ent[2] = st_rd_data_a;
      ent[3] = st_rd_data_b;
      off = 3'd0;
      for (int i = 0; i < 4; i++) begin
         ci          = 2'(i);
         slot        = y0_ff ^ ci[1];
         fresh[i]    = valid_ff[i] && (ent[i][ENTRY_W-1 -: EPOCH_W] != epoch_ff[slot]);
         num_calc[i] = fresh[i] ? nv_ff[NUM_W-1:0] + NUM_W'(off) : ent[i][NUM_W-1:0];
         off         = off + 3'(fresh[i]);
      end
      exhausted = ({1'b0, nv_ff} + (COUNT_W+1)'(off)) > {1'b0, NUM_LIMIT};

      // Record list: new vertices interleaved with indices for a triangle,
      // or all new vertices first and then both triangles for a full quad.
      // The list is only built while the corners are evaluated, so that it
      // stays fixed during emission.
      full_quad = &valid_ff;
      n = '0;
      if (state_ff == ST_EVAL) begin
         for (int i = 0; i < 4; i++) begin
            ci = 2'(i);
            if (fresh[i]) begin
               rec_kind_in[n]   = KIND_VERTEX;
               rec_corner_in[n] = ci;
               n = n + REC_IDX_W'(1);
            end
            if (!full_quad && valid_ff[i]) begin
               rec_kind_in[n]   = KIND_INDEX;
               rec_corner_in[n] = ci;
               n = n + REC_IDX_W'(1);
            end
         end
         if (full_quad) begin
            for (int k = 0; k < 6; k++) begin
               rec_kind_in[n]   = KIND_INDEX;
               rec_corner_in[n] = tri_corner(3'(k));
               n = n + REC_IDX_W'(1);
            end
         end
      end

      // Input decode.
      qv = {in_word.depth_bottom_right != 16'd0, in_word.depth_bottom_left != 16'd0,
            in_word.depth_top_right != 16'd0, in_word.depth_top_left != 16'd0};
      qv_cnt = 3'(qv[0]) + 3'(qv[1]) + 3'(qv[2]) + 3'(qv[3]);
      past_edge = (({{(CALC_W-10){1'b0}}, in_word.grid_x} + CALC_W'(1)) >= WIDTH_C) ||
                  (({{(CALC_W-10){1'b0}}, in_word.grid_y} + CALC_W'(1)) >= HEIGHT_C);

      sel        = ~pend_ff[0];
      sweep_addr = sel ? {{(CALC_W-CTR_W){1'b0}}, ctr_ff} + WIDTH_C
                       : {{(CALC_W-CTR_W){1'b0}}, ctr_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (|pend_ff) begin
               state_in = ST_SWEEP;
            end else if (in_valid) begin
               in_take = 1'b1;
               if (in_word.command == CMD_FRAME) begin
                  nv_in  = '0;
                  row_in = '0;
                  bump   = 2'b11;
               end else begin
                  // Row tracking: one row down retires the old top half,
                  // any other change retires both.
                  if (in_word.grid_y != row_ff) begin
                     if ({1'b0, in_word.grid_y} == {1'b0, row_ff} + 11'd1) begin
                        bump[row_ff[0]] = 1'b1;
                     end else begin
                        bump = 2'b11;
                     end
                     row_in = in_word.grid_y;
                  end
                  for (int i = 0; i < 4; i++) begin
                     addr_in[i] = corner_addr(in_word.grid_x, in_word.grid_y[0], 2'(i));
                  end
                  valid_in = qv;
                  y0_in    = in_word.grid_y[0];
                  if (!past_edge && (qv_cnt >= 3'd3)) begin
                     busy_in  = 1'b1;
                     state_in = ST_READ_TOP;
                  end
               end
            end
         end
         ST_READ_TOP: begin
            if (|pend_ff) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_READ_BOTTOM;
            end
         end
         ST_READ_BOTTOM: begin
            st_rd_addr_a  = addr_ff[2];
            st_rd_addr_b  = addr_ff[3];
            top_ent_in[0] = st_rd_data_a;
            top_ent_in[1] = st_rd_data_b;
            state_in      = ST_EVAL;
         end
         ST_EVAL: begin
            busy_in = 1'b0;
            if (exhausted) begin
               state_in = ST_IDLE;
            end else begin
               nv_in      = nv_ff + COUNT_W'(off);
               num_in     = num_calc;
               rec_cnt_in = n;
               rec_idx_in = '0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rec_valid = 1'b1;
            if (rec_ready) begin
               st_wr_en = (rec_kind_ff[rec_idx_ff] == KIND_VERTEX);
               if (rec_word.last) begin
                  state_in = ST_IDLE;
               end else begin
                  rec_idx_in = rec_idx_ff + REC_IDX_W'(1);
               end
            end
         end
         ST_SWEEP: begin
            // Tag every entry of one row half as stale, one per cycle.
            st_wr_en   = 1'b1;
            st_wr_addr = sweep_addr[ADDR_W-1:0];
            st_wr_data = {EPOCH_STALE, {NUM_W{1'b0}}};
            if (ctr_ff == CTR_LAST) begin
               ctr_in        = '0;
               pend_in[sel]  = 1'b0;
               epoch_in[sel] = EPOCH_FIRST;
               if (!pend_ff[~sel]) begin
                  state_in = busy_ff ? ST_READ_TOP : ST_IDLE;
               end
            end else begin
               ctr_in = ctr_ff + CTR_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Retiring a row half moves its epoch on; at the last epoch the half
      // gets a sweep instead.
      for (int s = 0; s < 2; s++) begin
         if (bump[s]) begin
            if (epoch_ff[s] == EPOCH_MAX) begin
               pend_in[s] = 1'b1;
            end else begin
               epoch_in[s] = epoch_ff[s] + EPOCH_W'(1);
            end
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         busy_ff     <= 1'b0;
         row_ff      <= '0;
         nv_ff       <= '0;
         epoch_ff[0] <= EPOCH_FIRST;
         epoch_ff[1] <= EPOCH_FIRST;
         pend_ff     <= 2'b11;
         ctr_ff      <= '0;
         rec_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         busy_ff     <= busy_in;
         row_ff      <= row_in;
         nv_ff       <= nv_in;
         epoch_ff    <= epoch_in;
         pend_ff     <= pend_in;
         ctr_ff      <= ctr_in;
         rec_idx_ff  <= rec_idx_in;
      end
      addr_ff       <= addr_in;
      valid_ff      <= valid_in;
      y0_ff         <= y0_in;
      top_ent_ff    <= top_ent_in;
      num_ff        <= num_in;
      rec_kind_ff   <= rec_kind_in;
      rec_corner_ff <= rec_corner_in;
      rec_cnt_ff    <= rec_cnt_in;
   end

endmodule

FILE: test/depth_grid_mesh_indexer_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth grid mesh indexer checker
// Watches the quad and record channels, keeps its own copy of the vertex
// numbering and the two-row store, and compares every record word with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module depth_grid_mesh_indexer_check
   import dgmi_pkg::*;
#(
   parameter int GRID_WIDTH_MAX  = 1024,
   parameter int GRID_HEIGHT_MAX = 1024
) (
   input  logic clock,
   input  logic reset,
   dgmi_req_if  req_chan,
   dgmi_rsp_if  rsp_chan,
   output int   error_count,
   output int   records_pending,
   output int   quad_count,
   output int   frame_count,
   output int   vertex_record_count,
   output int   index_record_count
);

   localparam int STORE_DEPTH = 2 * GRID_WIDTH_MAX;

   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BL = 2'd2;
   localparam logic [1:0] CORNER_BR = 2'd3;

   // Triangles 0-1-2 and 2-1-3, in the order their indices leave the block.
   localparam logic [1:0] TRIANGLE_CORNERS [6] = '{
      CORNER_TL, CORNER_TR, CORNER_BL, CORNER_BL, CORNER_TR, CORNER_BR
   };

   logic [COUNT_W-1:0] next_number;
   logic [NUM_W-1:0]   number_store [STORE_DEPTH];
   bit                 number_taken [STORE_DEPTH];
   logic [9:0]         top_row;
   rsp_word_type       pending_mesh_records [$];

   // Forget every number held in one row half of the store.
   function automatic void clear_row_half(input int half);
      for (int c = 0; c < GRID_WIDTH_MAX; c++) begin
         number_taken[half * GRID_WIDTH_MAX + c] = 1'b0;
      end
   endfunction

   function automatic void restart_numbering();
      next_number = '0;
      top_row     = '0;
      clear_row_half(0);
      clear_row_half(1);
   endfunction

   function automatic void queue_record(input kind_type kind, input logic [1:0] corner,
                                        input logic [NUM_W-1:0] number);
      rsp_word_type rec;
      rec.kind          = kind;
      rec.corner        = corner;
      rec.vertex_number = number;
      rec.last          = 1'b0;
      pending_mesh_records.push_back(rec);
   endfunction

   // Work out the records one accepted request word causes and queue them.
   function automatic void index_quad(input req_word_type w);
      int addr [4];
      bit live [4];
      int dead;
      int needed;
      int emitted;
      int row;
      int col;
      dead    = 0;
      needed  = 0;
      emitted = 0;

      if (w.command == CMD_FRAME) begin
         restart_numbering();
         return;
      end

      // Row tracking: a step down by one frees the old top row, anything else
      // frees both halves.
      if (w.grid_y != top_row) begin
         if (int'(w.grid_y) == int'(top_row) + 1) begin
            clear_row_half(int'(top_row[0]));
         end else begin
            clear_row_half(0);
            clear_row_half(1);
         end
         top_row = w.grid_y;
      end

      if (int'(w.grid_x) + 1 >= GRID_WIDTH_MAX || int'(w.grid_y) + 1 >= GRID_HEIGHT_MAX) begin
         return;
      end

      for (int i = 0; i < 4; i++) begin
         col     = int'(w.grid_x) + (i & 1);
         row     = int'(w.grid_y) + (i >> 1);
         addr[i] = (row & 1) * GRID_WIDTH_MAX + col;
      end
      live[0] = (w.depth_top_left != '0);
      live[1] = (w.depth_top_right != '0);
      live[2] = (w.depth_bottom_left != '0);
      live[3] = (w.depth_bottom_right != '0);
      for (int i = 0; i < 4; i++) begin
         if (!live[i]) dead++;
      end
      if (dead >= 2) return;

      // A quad that would run the numbering past its limit is dropped whole.
      for (int i = 0; i < 4; i++) begin
         if (live[i] && !number_taken[addr[i]]) needed++;
      end
      if (int'(next_number) + needed > int'(NUM_LIMIT)) return;

      // New vertices in corner order; with one dead corner each live corner's
      // index follows its own vertex record.
      for (int i = 0; i < 4; i++) begin
         if (live[i]) begin
            if (!number_taken[addr[i]]) begin
               number_taken[addr[i]] = 1'b1;
               number_store[addr[i]] = next_number[NUM_W-1:0];
               next_number++;
               queue_record(KIND_VERTEX, 2'(i), number_store[addr[i]]);
               emitted++;
            end
            if (dead == 1) begin
               queue_record(KIND_INDEX, 2'(i), number_store[addr[i]]);
               emitted++;
            end
         end
      end
      if (dead == 0) begin
         for (int k = 0; k < 6; k++) begin
            queue_record(KIND_INDEX, TRIANGLE_CORNERS[k],
                         number_store[addr[TRIANGLE_CORNERS[k]]]);
            emitted++;
         end
      end
      pending_mesh_records[pending_mesh_records.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] wanted,
                                       input logic [31:0] seen);
      if (seen !== wanted) begin
         $error("%s mismatch: expected %0d, actual %0d", name, wanted, seen);
         error_count++;
      end
   endfunction

   // Predict on every accepted request word, compare on every record word.
   always @(posedge clock) begin
      req_word_type quad_word;
      rsp_word_type wanted;
      if (reset) begin
         restart_numbering();
         pending_mesh_records.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            quad_word.command            = req_chan.command;
            quad_word.grid_x             = req_chan.grid_x;
            quad_word.grid_y             = req_chan.grid_y;
            quad_word.depth_top_left     = req_chan.depth_top_left;
            quad_word.depth_top_right    = req_chan.depth_top_right;
            quad_word.depth_bottom_left  = req_chan.depth_bottom_left;
            quad_word.depth_bottom_right = req_chan.depth_bottom_right;
            if (quad_word.command == CMD_FRAME) frame_count++;
            else quad_count++;
            index_quad(quad_word);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_mesh_records.size() == 0) begin
               $error("unexpected record word: kind %0d corner %0d vertex_number %0d last %0d",
                      rsp_chan.kind, rsp_chan.corner, rsp_chan.vertex_number, rsp_chan.last);
               error_count++;
            end else begin
               wanted = pending_mesh_records.pop_front();
               check_field("kind", 32'(wanted.kind), 32'(rsp_chan.kind));
               check_field("corner", 32'(wanted.corner), 32'(rsp_chan.corner));
               check_field("vertex_number", 32'(wanted.vertex_number),
                           32'(rsp_chan.vertex_number));
               check_field("last", 32'(wanted.last), 32'(rsp_chan.last));
               if (wanted.kind == KIND_VERTEX) vertex_record_count++;
               else index_record_count++;
            end
         end
      end
      records_pending <= pending_mesh_records.size();
   end

endmodule

FILE: test/depth_grid_mesh_indexer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth grid mesh indexer testbench
// Drives directed and random quad words through four idle/stall phases,
// with a short row-jump burst that keeps retiring both store rows, and
// leaves prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module depth_grid_mesh_indexer_tb;
   import dgmi_pkg::*;

   localparam int GRID_WIDTH_MAX    = 1024;
   localparam int GRID_HEIGHT_MAX   = 1024;
   localparam int RESET_CYCLES      = 7;
   localparam int WATCHDOG_LIMIT    = 10000;
   localparam int DRAIN_CYCLES      = 30;
   localparam int PHASE_ITEMS       = 95;
   localparam int ROW_BURST_ITEMS   = 40;
   localparam int EDGE_X            = GRID_WIDTH_MAX - 1;
   localparam int EDGE_Y            = GRID_HEIGHT_MAX - 1;
   localparam logic [15:0] DEPTH_NONE = 16'h0000;
   localparam logic [15:0] DEPTH_MIN  = 16'h0001;
   localparam logic [15:0] DEPTH_MAX  = 16'hFFFF;

   logic clock;
   logic reset;
   int   sender_idle_pct;
   int   receiver_stall_pct;
   int   random_sent;
   int   quiet_cycles;
   int   error_count;
   int   records_pending;
   int   quad_count;
   int   frame_count;
   int   vertex_record_count;
   int   index_record_count;

   dgmi_req_if req_chan ();
   dgmi_rsp_if rsp_chan ();

   depth_grid_mesh_indexer #(
      .GRID_WIDTH_MAX  (GRID_WIDTH_MAX),
      .GRID_HEIGHT_MAX (GRID_HEIGHT_MAX)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   depth_grid_mesh_indexer_check #(
      .GRID_WIDTH_MAX  (GRID_WIDTH_MAX),
      .GRID_HEIGHT_MAX (GRID_HEIGHT_MAX)
   ) mesh_check (
      .clock               (clock),
      .reset               (reset),
      .req_chan            (req_chan),
      .rsp_chan            (rsp_chan),
      .error_count         (error_count),
      .records_pending     (records_pending),
      .quad_count          (quad_count),
      .frame_count         (frame_count),
      .vertex_record_count (vertex_record_count),
      .index_record_count  (index_record_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The record receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no word accepted for %0d cycles, %0d records outstanding",
                  quiet_cycles, records_pending);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type make_word(input command_type cmd, input int x, input int y,
                                              input logic [15:0] tl, input logic [15:0] tr,
                                              input logic [15:0] bl, input logic [15:0] br);
      req_word_type w;
      w.command            = cmd;
      w.grid_x             = 10'(x);
      w.grid_y             = 10'(y);
      w.depth_top_left     = tl;
      w.depth_top_right    = tr;
      w.depth_bottom_left  = bl;
      w.depth_bottom_right = br;
      return w;
   endfunction

   // Zero (no measurement) with the given chance, else any nonzero depth.
   function automatic logic [15:0] random_depth(input int zero_pct);
      if ($urandom_range(99) < zero_pct) return DEPTH_NONE;
      return 16'($urandom_range(1, 65535));
   endfunction

   // Present one word from a falling edge and hold it until it is taken.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid              <= 1'b1;
      req_chan.command            <= w.command;
      req_chan.grid_x             <= w.grid_x;
      req_chan.grid_y             <= w.grid_y;
      req_chan.depth_top_left     <= w.depth_top_left;
      req_chan.depth_top_right    <= w.depth_top_right;
      req_chan.depth_bottom_left  <= w.depth_bottom_left;
      req_chan.depth_bottom_right <= w.depth_bottom_right;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_quad(input int x, input int y, input logic [15:0] tl,
                            input logic [15:0] tr, input logic [15:0] bl,
                            input logic [15:0] br);
      send_word(make_word(CMD_QUAD, x, y, tl, tr, bl, br));
   endtask

   // A small rectangle of quads in raster order, often after a frame start.
   task automatic send_patch();
      int w;
      int h;
      int x0;
      int y0;
      w  = $urandom_range(1, 6);
      h  = $urandom_range(1, 4);
      x0 = $urandom_range(0, GRID_WIDTH_MAX - w);
      y0 = $urandom_range(0, GRID_HEIGHT_MAX - h);
      if ($urandom_range(2) == 0) begin
         send_word(make_word(CMD_FRAME, $urandom, $urandom, 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom)));
         random_sent++;
      end
      for (int r = 0; r < h; r++) begin
         for (int c = 0; c < w; c++) begin
            send_quad(x0 + c, y0 + r, random_depth(12), random_depth(12),
                      random_depth(12), random_depth(12));
            random_sent++;
         end
      end
   endtask

   // Mostly well-formed patches, the rest scattered words of any shape.
   task automatic run_random(input int count);
      random_sent = 0;
      while (random_sent < count) begin
         if ($urandom_range(99) < 75) begin
            send_patch();
         end else begin
            send_word(make_word(($urandom_range(9) == 0) ? CMD_FRAME : CMD_QUAD,
                                $urandom, $urandom, random_depth(30), random_depth(30),
                                random_depth(30), random_depth(30)));
            random_sent++;
         end
      end
   endtask

   initial begin
      reset                       = 1'b1;
      sender_idle_pct             = 0;
      receiver_stall_pct          = 0;
      req_chan.valid              = 1'b0;
      req_chan.command            = CMD_FRAME;
      req_chan.grid_x             = '0;
      req_chan.grid_y             = '0;
      req_chan.depth_top_left     = '0;
      req_chan.depth_top_right    = '0;
      req_chan.depth_bottom_left  = '0;
      req_chan.depth_bottom_right = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: frame starts with extreme fields, each single dead corner, a pair
      // and all four dead, corner reuse, both grid edges, and each kind of row change.
      send_word(make_word(CMD_FRAME, EDGE_X, EDGE_Y, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX,
                          DEPTH_MAX));
      send_quad(0, 0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(1, 0, DEPTH_MIN, DEPTH_MIN, DEPTH_MIN, DEPTH_MIN);
      send_quad(2, 0, DEPTH_NONE, DEPTH_MAX, DEPTH_MIN, DEPTH_MAX);
      send_quad(3, 0, DEPTH_MAX, DEPTH_NONE, DEPTH_MAX, DEPTH_MIN);
      send_quad(4, 0, 16'h5555, 16'hAAAA, DEPTH_NONE, 16'h5555);
      send_quad(5, 0, 16'hAAAA, 16'h5555, 16'hAAAA, DEPTH_NONE);
      send_quad(6, 0, DEPTH_NONE, DEPTH_MAX, DEPTH_NONE, DEPTH_MAX);
      send_quad(7, 0, DEPTH_NONE, DEPTH_NONE, DEPTH_NONE, DEPTH_NONE);
      send_quad(EDGE_X - 1, 0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(EDGE_X, 0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(0, 1, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(1, 1, DEPTH_MAX, DEPTH_MIN, DEPTH_MAX, DEPTH_MIN);
      send_quad(0, 5, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(0, 3, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(0, EDGE_Y - 1, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(5, EDGE_Y, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(0, 0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_word(make_word(CMD_FRAME, 0, 0, DEPTH_NONE, DEPTH_NONE, DEPTH_NONE, DEPTH_NONE));
      send_quad(0, 0, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(EDGE_X - 1, EDGE_Y - 1, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX);
      send_quad(EDGE_X - 2, EDGE_Y - 1, DEPTH_MIN, DEPTH_MAX, DEPTH_MIN, DEPTH_MAX);

      // Row-jump burst past the right edge: nothing comes out, but every word
      // frees both row halves. Now and then two real quads check that freed
      // entries are not taken for live ones.
      for (int k = 0; k < ROW_BURST_ITEMS; k++) begin
         if (k % 20 == 19) begin
            send_quad(3, 40, DEPTH_MAX, random_depth(0), random_depth(0), DEPTH_MAX);
            send_quad(4, 40, random_depth(0), DEPTH_MAX, DEPTH_MAX, random_depth(0));
         end else begin
            send_quad(EDGE_X, (k % 2 == 0) ? 200 : 600, DEPTH_MAX, DEPTH_MAX, DEPTH_MAX,
                      DEPTH_MAX);
         end
      end

      // Random phases: free flow, slow sender, slow receiver, then both.
      run_random(PHASE_ITEMS);
      sender_idle_pct = 75;
      run_random(PHASE_ITEMS);
      sender_idle_pct    = 0;
      receiver_stall_pct = 75;
      run_random(PHASE_ITEMS);
      sender_idle_pct    = 27;
      receiver_stall_pct = 27;
      run_random(PHASE_ITEMS);
      req_chan.valid <= 1'b0;

      wait (records_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d quad words and %0d frame starts under four handshake phases.",
               quad_count, frame_count);
      $display("Compared %0d new-vertex records and %0d triangle-index records.",
               vertex_record_count, index_record_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
